FILE: sv/assert_macros.svh
// Assertion helpers used by the pixel converter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/ycc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ycc_pkg;

    // Sample format
    localparam int SAMPLE_BITS = 8;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam int HALF_VAL = 2 ** (SAMPLE_BITS - 1);

    // Arithmetic widths
    localparam int XW     = SAMPLE_BITS + 2;    // signed operand (offset chroma)
    localparam int COEF_W = 36;                 // signed coefficient, scale 2^32
    localparam int PROD_W = COEF_W + XW;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FRAC_W = 32;
    localparam int Q_W    = SUM_W - FRAC_W;

    // Register map
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DIRECTION = '0;

    // Direction codes
    localparam logic DIR_YUV2RGB = 1'b0;
    localparam logic DIR_RGB2YUV = 1'b1;

    // Coefficients [output channel][input term]
    localparam logic signed [COEF_W-1:0] COEF_YUV2RGB [3][3] = '{
        '{ 36'sd4294967296, -36'sd5235,       36'sd6021542382},
        '{ 36'sd4294967296, -36'sd1478051483, -36'sd3067191433},
        '{ 36'sd4294967296,  36'sd7610682332,  36'sd1745}
    };
    localparam logic signed [COEF_W-1:0] COEF_RGB2YUV [3][3] = '{
        '{ 36'sd1284195221,  36'sd2521145803,  36'sd489626272},
        '{-36'sd724715602,  -36'sd1422768046,  36'sd2147483648},
        '{ 36'sd2147483648, -36'sd1798251267, -36'sd349232381}
    };

    // Per-channel control
    typedef struct packed {
        logic signed [COEF_W-1:0] k0;
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic                     add_half;
    } chan_ctl_t;

    // Payloads
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] chan0_in;
        logic [SAMPLE_BITS-1:0] chan1_in;
        logic [SAMPLE_BITS-1:0] chan2_in;
        logic [SAMPLE_BITS-1:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] chan0_out;
        logic [SAMPLE_BITS-1:0] chan1_out;
        logic [SAMPLE_BITS-1:0] chan2_out;
        logic [SAMPLE_BITS-1:0] alpha_out;
    } pix_out_t;

endpackage

`default_nettype wire

FILE: sv/ycc_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module ycc_chan (
    input  ycc_pkg::chan_ctl_t                  ctl,
    input  logic signed [ycc_pkg::XW-1:0]       x0,
    input  logic signed [ycc_pkg::XW-1:0]       x1,
    input  logic signed [ycc_pkg::XW-1:0]       x2,
    output logic [ycc_pkg::SAMPLE_BITS-1:0]     sample
);
    import ycc_pkg::*;

    localparam logic signed [SUM_W-1:0] TRUNC_BIAS =
        {{(SUM_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};
    localparam logic signed [Q_W:0] HALF_Q = (Q_W+1)'(HALF_VAL);
    localparam logic signed [Q_W:0] MAX_Q  = (Q_W+1)'(SAMPLE_MAX);

    logic signed [PROD_W-1:0] p0, p1, p2;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  biased;
    logic signed [Q_W-1:0]    quot;
    logic signed [Q_W:0]      res;

    // Weighted terms
    assign p0 = ctl.k0 * x0;
    assign p1 = ctl.k1 * x1;
    assign p2 = ctl.k2 * x2;

    // Sum and divide by 2^32, rounding toward zero
    assign sum    = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
    assign biased = sum + (sum[SUM_W-1] ? TRUNC_BIAS : '0);
    assign quot   = biased[SUM_W-1:FRAC_W];

    // Recenter chroma, then clamp to sample range
    assign res = $signed({quot[Q_W-1], quot}) + (ctl.add_half ? HALF_Q : '0);

    always_comb
    begin
        priority if (res[Q_W])
        begin
            sample = '0;
        end
        else if (res > MAX_Q)
        begin
            sample = SAMPLE_MAX;
        end
        else
        begin
            sample = res[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: sv/ycbcr_rgb_pixel_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// pix       pix_valid / pix_ready   pix (Y,U,V,A or R,G,B,A)
// res       res_valid / res_ready   res (R,G,B,A or Y,U,V,A)
// cfg       APB psel/penable        paddr, pwdata, prdata (direction at 0x0)
//
// One pixel per clock sustained while results are taken.
// The pixel is held in an input register, converted by three multiply-sum
// channels combinationally, and captured in the result register.
// Reset clears the valid flags and sets direction to YUV to RGB.
// A stalled result holds; a new pixel is still taken while the input
// register is empty or advancing.

module ycbcr_rgb_pixel_converter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // pixel requests
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  ycc_pkg::pix_in_t              pix,
    // results
    output logic                          res_valid,
    input  logic                          res_ready,
    output ycc_pkg::pix_out_t             res,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ycc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ycc_pkg::*;

`include "assert_macros.svh"

    logic                   direction_reg;
    logic                   cfg_write;
    logic [REG_IDX_W-1:0]   reg_idx;

    logic                   s1_valid_reg, s1_valid_next;
    pix_in_t                s1_reg;
    logic                   s1_advance;
    logic                   pix_accept;

    logic                   res_valid_reg, res_valid_next;
    pix_out_t               res_reg;

    logic signed [XW-1:0]   xa, xb, xc;
    chan_ctl_t              ctl [3];
    logic [SAMPLE_BITS-1:0] conv [3];

    // Configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_YUV2RGB;
        end
        else if (cfg_write && (reg_idx == REG_DIRECTION))
        begin
            direction_reg <= pwdata[0];
        end
    end

    assign prdata = (reg_idx == REG_DIRECTION) ? {31'b0, direction_reg} : '0;

    // Handshake control
    assign s1_advance = s1_valid_reg && (!res_valid_reg || res_ready);
    assign pix_ready  = !s1_valid_reg || s1_advance;
    assign pix_accept = pix_valid && pix_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pix_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the accepted pixel
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_reg <= pix;
        end
    end

    // Form operands: offset chroma by minus half-scale for YUV input
    assign xa = $signed({2'b00, s1_reg.chan0_in});
    assign xb = $signed({2'b00, s1_reg.chan1_in})
              - ((direction_reg == DIR_YUV2RGB) ? XW'(HALF_VAL) : '0);
    assign xc = $signed({2'b00, s1_reg.chan2_in})
              - ((direction_reg == DIR_YUV2RGB) ? XW'(HALF_VAL) : '0);

    // One multiply-sum channel per output
    for (genvar g = 0; g < 3; g++)
    begin : g_chan
        always_comb
        begin
            if (direction_reg == DIR_RGB2YUV)
            begin
                ctl[g].k0       = COEF_RGB2YUV[g][0];
                ctl[g].k1       = COEF_RGB2YUV[g][1];
                ctl[g].k2       = COEF_RGB2YUV[g][2];
                ctl[g].add_half = (g != 0);
            end
            else
            begin
                ctl[g].k0       = COEF_YUV2RGB[g][0];
                ctl[g].k1       = COEF_YUV2RGB[g][1];
                ctl[g].k2       = COEF_YUV2RGB[g][2];
                ctl[g].add_half = 1'b0;
            end
        end

        ycc_chan u_chan (
            .ctl    (ctl[g]),
            .x0     (xa),
            .x1     (xb),
            .x2     (xc),
            .sample (conv[g])
        );
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            res_reg.chan0_out <= conv[0];
            res_reg.chan1_out <= conv[1];
            res_reg.chan2_out <= conv[2];
            res_reg.alpha_out <= s1_reg.alpha_in;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks
    `ASSERT_IMPLIES(a_full_blocks_input, clk, rst_n,
        s1_valid_reg && res_valid_reg && !res_ready, !pix_ready)
    `ASSERT_NEXT(a_advance_fills_result, clk, rst_n, s1_advance, res_valid_reg)
    `ASSERT_NEXT(a_alpha_passes, clk, rst_n, s1_advance,
        res_reg.alpha_out == $past(s1_reg.alpha_in))
    `ASSERT_NEXT(a_accept_fills_input, clk, rst_n, pix_accept, s1_valid_reg)

endmodule

`default_nettype wire

FILE: test/ycbcr_pixel_checker.sv
`timescale 1ns / 1ps

module ycbcr_pixel_checker
    import ycc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    input  logic                pix_ready,
    input  pix_in_t             pix,
    input  logic                res_valid,
    input  logic                res_ready,
    input  pix_out_t            res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  pending
);

    localparam logic [ADDR_W-1:0] DIR_ADDR = {REG_DIRECTION, 2'b00};

    // Q32 weights of the conversion matrices
    localparam longint ONE_Q32  = 64'sd4294967296;
    localparam longint HALF_Q32 = 64'sd2147483648;
    localparam longint K_RU     = 64'sd5235;
    localparam longint K_RV     = 64'sd6021542382;
    localparam longint K_GU     = 64'sd1478051483;
    localparam longint K_GV     = 64'sd3067191433;
    localparam longint K_BU     = 64'sd7610682332;
    localparam longint K_BV     = 64'sd1745;
    localparam longint K_YR     = 64'sd1284195221;
    localparam longint K_YG     = 64'sd2521145803;
    localparam longint K_YB     = 64'sd489626272;
    localparam longint K_UR     = 64'sd724715602;
    localparam longint K_UG     = 64'sd1422768046;
    localparam longint K_VG     = 64'sd1798251267;
    localparam longint K_VB     = 64'sd349232381;

    localparam longint MAX_L  = longint'(SAMPLE_MAX);
    localparam longint HALF_L = longint'(HALF_VAL);

    logic     direction_q;
    pix_out_t expected_pixels[$];

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input longint x);
        if (x < 0)
            return '0;
        if (x > MAX_L)
            return SAMPLE_MAX;
        return x[SAMPLE_BITS-1:0];
    endfunction

    // Convert one pixel; signed division truncates toward zero
    function automatic pix_out_t convert_pixel(input pix_in_t p, input logic dir);
        longint   a;
        longint   b;
        longint   c;
        longint   u;
        longint   v;
        longint   s0;
        longint   s1;
        longint   s2;
        pix_out_t r;
        a = longint'(p.chan0_in);
        b = longint'(p.chan1_in);
        c = longint'(p.chan2_in);
        if (dir == DIR_YUV2RGB)
        begin
            u  = b - HALF_L;
            v  = c - HALF_L;
            s0 = (ONE_Q32 * a - K_RU * u + K_RV * v) / ONE_Q32;
            s1 = (ONE_Q32 * a - K_GU * u - K_GV * v) / ONE_Q32;
            s2 = (ONE_Q32 * a + K_BU * u + K_BV * v) / ONE_Q32;
        end
        else
        begin
            s0 = (K_YR * a + K_YG * b + K_YB * c) / ONE_Q32;
            s1 = (HALF_Q32 * c - K_UR * a - K_UG * b) / ONE_Q32 + HALF_L;
            s2 = (HALF_Q32 * a - K_VG * b - K_VB * c) / ONE_Q32 + HALF_L;
        end
        r.chan0_out = clamp_sample(s0);
        r.chan1_out = clamp_sample(s1);
        r.chan2_out = clamp_sample(s2);
        r.alpha_out = p.alpha_in;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            direction_q = DIR_YUV2RGB;
            expected_pixels.delete();
            pending = 0;
        end
        else
        begin
            // Track register writes and verify reads of the direction register
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == DIR_ADDR)
                        direction_q = pwdata[0];
                end
                else if (paddr == DIR_ADDR && prdata !== {31'b0, direction_q})
                begin
                    report_mismatch($sformatf("direction read %h, want %h",
                                              prdata, {31'b0, direction_q}));
                end
            end

            // Predict each accepted pixel request
            if (pix_valid && pix_ready)
                expected_pixels.push_back(convert_pixel(pix, direction_q));

            // Compare each accepted result with the oldest prediction
            if (res_valid && res_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", res));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (res.chan0_out !== want.chan0_out)
                        report_mismatch($sformatf("chan0_out %h, want %h",
                                                  res.chan0_out, want.chan0_out));
                    if (res.chan1_out !== want.chan1_out)
                        report_mismatch($sformatf("chan1_out %h, want %h",
                                                  res.chan1_out, want.chan1_out));
                    if (res.chan2_out !== want.chan2_out)
                        report_mismatch($sformatf("chan2_out %h, want %h",
                                                  res.chan2_out, want.chan2_out));
                    if (res.alpha_out !== want.alpha_out)
                        report_mismatch($sformatf("alpha_out %h, want %h",
                                                  res.alpha_out, want.alpha_out));
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

FILE: test/tb_ycbcr_rgb_pixel_converter_unit.sv
`timescale 1ns / 1ps

module tb_ycbcr_rgb_pixel_converter_unit;
    import ycc_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_HALF = 167;
    localparam logic [ADDR_W-1:0] DIR_ADDR   = {REG_DIRECTION, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_DIRECTION, 2'b00};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              pix_valid = 1'b0;
    logic              pix_ready;
    pix_in_t           pix       = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    pix_out_t          res;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int mismatches;
    int pending;

    ycbcr_rgb_pixel_converter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    ycbcr_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    // Stall the result channel at random
    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Bias samples toward the range ends
    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_BITS'($urandom_range(int'(SAMPLE_MAX)));
        endcase
    endfunction

    // Start at a rising edge; return at the edge that accepts the request
    task automatic send_pixel(input pix_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix       <= p;
        pix_valid <= 1'b1;
        @(negedge clk);
        while (!pix_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold off new requests until every result has been taken
    task automatic drain_pixels();
        pix_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // One APB transfer: setup, access until pready, then idle
    task automatic apb_access(input logic is_write, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int pause_at;
        logic dir;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed YUV to RGB: neutral gray, saturation both ways, alpha ends
        apb_access(1'b0, DIR_ADDR, '0);
        send_pixel(pix_in_t'{8'd0,   8'd0,   8'd0,   8'd0});
        send_pixel(pix_in_t'{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(pix_in_t'{8'd0,   8'd128, 8'd128, 8'h5A});
        send_pixel(pix_in_t'{8'd255, 8'd128, 8'd128, 8'hA5});
        send_pixel(pix_in_t'{8'd128, 8'd0,   8'd255, 8'd1});
        send_pixel(pix_in_t'{8'd128, 8'd255, 8'd0,   8'd254});
        send_pixel(pix_in_t'{8'd16,  8'd255, 8'd255, 8'd128});
        send_pixel(pix_in_t'{8'd235, 8'd0,   8'd0,   8'd127});

        // Wide write keeps only bit 0; a write to an unmapped register is dropped
        drain_pixels();
        apb_access(1'b1, DIR_ADDR, {31'h7FFF_FFFF, DIR_RGB2YUV});
        apb_access(1'b1, SPARE_ADDR, {31'h0, DIR_YUV2RGB});
        apb_access(1'b0, DIR_ADDR, '0);

        // Directed RGB to YUV: black, white, primaries and secondaries
        send_pixel(pix_in_t'{8'd0,   8'd0,   8'd0,   8'd255});
        send_pixel(pix_in_t'{8'd255, 8'd255, 8'd255, 8'd0});
        send_pixel(pix_in_t'{8'd255, 8'd0,   8'd0,   8'h33});
        send_pixel(pix_in_t'{8'd0,   8'd255, 8'd0,   8'hCC});
        send_pixel(pix_in_t'{8'd0,   8'd0,   8'd255, 8'h0F});
        send_pixel(pix_in_t'{8'd255, 8'd255, 8'd0,   8'hF0});
        send_pixel(pix_in_t'{8'd0,   8'd255, 8'd255, 8'h81});
        send_pixel(pix_in_t'{8'd255, 8'd0,   8'd255, 8'h7E});

        // Random traffic in three idling regimes, both directions in each
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 25;
                    recv_idle_pct <= 52;
                end
                1:
                begin
                    send_idle_pct <= 52;
                    recv_idle_pct <= 25;
                end
                default:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int half = 0; half < 2; half++)
            begin
                dir = ((phase + half) % 2 == 0) ? DIR_YUV2RGB : DIR_RGB2YUV;
                drain_pixels();
                apb_access(1'b1, DIR_ADDR, {31'($urandom()), dir});
                apb_access(1'b0, DIR_ADDR, '0);
                pause_at = $urandom_range(ITEMS_PER_HALF - 1);
                for (int i = 0; i < ITEMS_PER_HALF; i++)
                begin
                    if (i == pause_at)
                        drain_pixels();
                    send_pixel(pix_in_t'{rand_sample(), rand_sample(),
                                         rand_sample(), rand_sample()});
                end
            end
        end

        // Let the pipeline empty, then give the verdict
        drain_pixels();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ycc_pkg.sv
sv/ycc_chan.sv
sv/ycbcr_rgb_pixel_converter_unit.sv
test/ycbcr_pixel_checker.sv
test/tb_ycbcr_rgb_pixel_converter_unit.sv
